// ===== rtl/core/dott_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline-ordered timer table package
// Shared constants, command and run mode codes, and the transfer structs.
// ----------------------------------------------------------------------------
package dott_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_BITS = 4;
  localparam int TIME_BITS = 48;
  localparam int PER_BITS  = 32;
  localparam int LIM_BITS  = 16;

  localparam logic [LIM_BITS-1:0]  JUMP_LIMIT_RESET = 16'd240;
  localparam logic [TIME_BITS-1:0] TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_REARM  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_CHG    = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;

  localparam logic [1:0] RUN_OFF    = 2'd0;
  localparam logic [1:0] RUN_ONCE   = 2'd1;
  localparam logic [1:0] RUN_REPEAT = 2'd2;
  localparam logic [1:0] RUN_ALIAS  = 2'd3;

  typedef struct packed {
    logic [2:0]                  mode;
    logic [SLOT_BITS-1:0]        timer_slot;
    logic [PER_BITS-1:0]         delay_value;
    logic [1:0]                  run_mode;
    logic signed [TIME_BITS-1:0] new_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] fired_slot;
    logic                 last_fired;
  } out_item_t;

  typedef struct packed {
    logic                 lr_we;
    logic                 per_we;
    logic [SLOT_BITS-1:0] addr;
    logic [TIME_BITS-1:0] lr_data;
    logic [PER_BITS-1:0]  per_data;
  } mem_wr_t;

endpackage

// ===== rtl/core/deadline_ordered_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// Deadline-ordered timer table core
// Sixteen timer slots fired earliest deadline first on each time update.
// ----------------------------------------------------------------------------
// Slot commands (init, rearm, stop, change delay) are applied as they are accepted.
// A time update makes a shift pass through the slot memory, then a scan of the
// pending deadlines for each fired slot, each expiry waiting for room in the
// output register, plus one closing scan when nothing fires.
// Reset clears the run modes to never, the current time to zero and the jump
// limit to 240; the slot memory needs no clearing pass.
module deadline_ordered_timer_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dott_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dott_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [dott_pkg::LIM_BITS-1:0] cfg_data
);

  // Configuration register: forward steps larger than this count as a jump.
  logic [dott_pkg::LIM_BITS-1:0]  jump_limit;

  logic                           emit_ok;
  logic                           emit;
  dott_pkg::out_item_t            res;
  logic [dott_pkg::SLOT_BITS-1:0] rd_addr;
  logic [dott_pkg::TIME_BITS-1:0] lr_q;
  logic [dott_pkg::PER_BITS-1:0]  per_q;
  dott_pkg::mem_wr_t              wr;

  // The output register parts the two sides: a new result may be loaded in
  // the same cycle as the waiting one completes its transfer.
  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= dott_pkg::JUMP_LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        jump_limit <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

  // The sequencer owns the run modes and the pending deadlines; last-run times
  // and periods live in the slot memory.
  dott_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .jump_limit (jump_limit),
    .emit_ok    (emit_ok),
    .emit       (emit),
    .res        (res),
    .rd_addr    (rd_addr),
    .lr_q       (lr_q),
    .per_q      (per_q),
    .wr         (wr)
  );

  dott_slot_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .lr_q    (lr_q),
    .per_q   (per_q)
  );

endmodule

// ===== rtl/core/dott_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Slot memory
// Last-run and period stores, one write port, registered read port.
// ----------------------------------------------------------------------------
module dott_slot_mem (
  input  logic                              clk,
  input  dott_pkg::mem_wr_t                 wr,
  input  logic [dott_pkg::SLOT_BITS-1:0]    rd_addr,
  output logic [dott_pkg::TIME_BITS-1:0]    lr_q,
  output logic [dott_pkg::PER_BITS-1:0]     per_q
);

  logic [dott_pkg::TIME_BITS-1:0] lr_mem  [dott_pkg::NUM_SLOTS];
  logic [dott_pkg::PER_BITS-1:0]  per_mem [dott_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.lr_we) begin
      lr_mem[wr.addr] <= wr.lr_data;
    end
    if (wr.per_we) begin
      per_mem[wr.addr] <= wr.per_data;
    end
    lr_q  <= lr_mem[rd_addr];
    per_q <= per_mem[rd_addr];
  end

endmodule

// ===== rtl/core/dott_seq.sv =====
// ----------------------------------------------------------------------------
// Timer table sequencer
// Runs commands, the shift and eligibility pass, and the earliest-first scans.
// ----------------------------------------------------------------------------
module dott_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  dott_pkg::in_item_t                in_item,
  output logic                              in_ready,
  input  logic [dott_pkg::LIM_BITS-1:0]     jump_limit,
  input  logic                              emit_ok,
  output logic                              emit,
  output dott_pkg::out_item_t               res,
  output logic [dott_pkg::SLOT_BITS-1:0]    rd_addr,
  input  logic [dott_pkg::TIME_BITS-1:0]    lr_q,
  input  logic [dott_pkg::PER_BITS-1:0]     per_q,
  output dott_pkg::mem_wr_t                 wr
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [dott_pkg::SLOT_BITS-1:0] LAST_SLOT =
    dott_pkg::SLOT_BITS'(dott_pkg::NUM_SLOTS - 1);

  logic [1:0]                        state;
  logic [dott_pkg::TIME_BITS-1:0]    cur;
  logic [dott_pkg::TIME_BITS-1:0]    t_new;
  logic [dott_pkg::TIME_BITS-1:0]    fix;
  logic                              jump;
  logic [1:0]                        run_mode_r [dott_pkg::NUM_SLOTS];
  logic [dott_pkg::SLOT_BITS:0]      cnt;
  logic                              v1;
  logic                              v2;
  logic [dott_pkg::SLOT_BITS-1:0]    a1;
  logic [dott_pkg::SLOT_BITS-1:0]    a2;
  logic [dott_pkg::TIME_BITS-1:0]    b_lr;
  logic [dott_pkg::PER_BITS-1:0]     b_per;
  logic                              b_arm;
  logic [dott_pkg::NUM_SLOTS-1:0]    pend;
  logic [dott_pkg::TIME_BITS-1:0]    dl [dott_pkg::NUM_SLOTS];
  logic [dott_pkg::SLOT_BITS-1:0]    sc;
  logic                              found;
  logic [dott_pkg::SLOT_BITS-1:0]    best;
  logic [dott_pkg::TIME_BITS-1:0]    bdl;
  logic                              best_always;

  logic                              accept;
  logic [dott_pkg::PER_BITS-1:0]     per_clamp;
  logic [1:0]                        mode_norm;
  logic [dott_pkg::TIME_BITS-1:0]    diff;
  logic                              back;
  logic                              jump_c;
  logic [dott_pkg::SLOT_BITS-1:0]    mode_idx;
  logic [1:0]                        m_sel;
  logic [dott_pkg::TIME_BITS-1:0]    lr_s;
  logic [dott_pkg::TIME_BITS:0]      d;
  logic [dott_pkg::TIME_BITS-1:0]    nu;
  logic                              elig;
  logic                              take;
  logic [dott_pkg::NUM_SLOTS-1:0]    rest;
  logic                              last;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign per_clamp = (in_item.delay_value == '0) ? dott_pkg::PER_BITS'(1)
                                                 : in_item.delay_value;
  assign mode_norm = (in_item.run_mode == dott_pkg::RUN_ALIAS) ? dott_pkg::RUN_ONCE
                                                              : in_item.run_mode;
  assign diff      = in_item.new_time - cur;
  assign back      = in_item.new_time < $signed(cur);
  assign jump_c    = back || (diff > {{(dott_pkg::TIME_BITS-dott_pkg::LIM_BITS){1'b0}},
                                      jump_limit});
  assign rd_addr   = cnt[dott_pkg::SLOT_BITS-1:0];
  assign mode_idx  = (state == S_SHIFT) ? a1 : sc;
  assign m_sel     = run_mode_r[mode_idx];
  assign lr_s      = lr_q + fix;
  assign d         = {1'b0, b_lr} + {{(dott_pkg::TIME_BITS+1-dott_pkg::PER_BITS){1'b0}},
                                     b_per};
  assign nu        = t_new ^ dott_pkg::TIME_SIGN;
  assign elig      = b_arm && !d[dott_pkg::TIME_BITS] &&
                     (nu > d[dott_pkg::TIME_BITS-1:0]);
  assign take      = pend[sc] && (!found || (dl[sc] < bdl));
  assign rest      = pend & ~(dott_pkg::NUM_SLOTS'(1) << best);
  assign last      = (rest == '0);
  assign emit      = (state == S_EMIT) && found && emit_ok;
  assign res       = '{fired_slot: best, last_fired: last};

  always_comb begin
    wr = '0;
    unique case (state)
      S_IDLE: begin
        wr.addr     = in_item.timer_slot;
        wr.per_data = per_clamp;
        wr.lr_data  = cur - {{(dott_pkg::TIME_BITS-dott_pkg::PER_BITS){1'b0}}, per_clamp};
        if (accept) begin
          wr.lr_we  = (in_item.mode == dott_pkg::CMD_INIT);
          wr.per_we = (in_item.mode == dott_pkg::CMD_INIT) ||
                      (in_item.mode == dott_pkg::CMD_REARM) ||
                      (in_item.mode == dott_pkg::CMD_CHG);
        end
      end
      S_SHIFT: begin
        wr.addr    = a1;
        wr.lr_data = lr_s;
        wr.lr_we   = v1 && jump && (m_sel != dott_pkg::RUN_OFF);
      end
      S_EMIT: begin
        wr.addr    = best;
        wr.lr_data = t_new;
        wr.lr_we   = emit;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      found <= 1'b0;
      pend  <= '0;
      cnt   <= '0;
      for (int i = 0; i < dott_pkg::NUM_SLOTS; i++) begin
        run_mode_r[i] <= dott_pkg::RUN_OFF;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_item.mode)
              dott_pkg::CMD_INIT, dott_pkg::CMD_REARM: begin
                run_mode_r[in_item.timer_slot] <= mode_norm;
              end
              dott_pkg::CMD_STOP: begin
                run_mode_r[in_item.timer_slot] <= dott_pkg::RUN_OFF;
              end
              dott_pkg::CMD_UPDATE: begin
                if (in_item.new_time != cur) begin
                  t_new <= in_item.new_time;
                  cur   <= in_item.new_time;
                  fix   <= diff - dott_pkg::TIME_BITS'(1);
                  jump  <= jump_c;
                  cnt   <= '0;
                  state <= S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (!cnt[dott_pkg::SLOT_BITS]) begin
            cnt <= cnt + 1'b1;
          end
          v1    <= !cnt[dott_pkg::SLOT_BITS];
          a1    <= cnt[dott_pkg::SLOT_BITS-1:0];
          v2    <= v1;
          a2    <= a1;
          b_lr  <= ((jump && (m_sel != dott_pkg::RUN_OFF)) ? lr_s : lr_q)
                   ^ dott_pkg::TIME_SIGN;
          b_per <= per_q;
          b_arm <= (m_sel != dott_pkg::RUN_OFF);
          if (v2) begin
            pend[a2] <= elig;
            dl[a2]   <= d[dott_pkg::TIME_BITS-1:0];
            if (a2 == LAST_SLOT) begin
              sc    <= '0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            found       <= 1'b1;
            best        <= sc;
            bdl         <= dl[sc];
            best_always <= (m_sel == dott_pkg::RUN_REPEAT);
          end
          sc <= sc + 1'b1;
          if (sc == LAST_SLOT) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!found) begin
            state <= S_IDLE;
          end else if (emit_ok) begin
            pend[best] <= 1'b0;
            if (!best_always) begin
              run_mode_r[best] <= dott_pkg::RUN_OFF;
            end
            found <= 1'b0;
            sc    <= '0;
            state <= last ? S_IDLE : S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/deadline_ordered_timer_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// Deadline-ordered timer table core testbench
// Drives slot commands and time updates through the valid/ready input
// channel, predicts the order in which slots expire on every time update,
// and checks each fired-slot transfer against that prediction. A directed
// table comes first, then randomised timer traffic under several jump
// limits, with random idling on both channels.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_table_core_tb;

  // Clock, reset and the ports of the block.
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  dott_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dott_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [dott_pkg::LIM_BITS-1:0] cfg_data = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  deadline_ordered_timer_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Our own copy of the timer table, kept in step with every accepted
  // transfer. Slots that have never seen an init are tracked so that a
  // rearm is only ever sent to a slot whose last-run time is defined.
  logic [dott_pkg::TIME_BITS-1:0] now_time;
  logic [dott_pkg::TIME_BITS-1:0] slot_lr [dott_pkg::NUM_SLOTS];
  logic [dott_pkg::PER_BITS-1:0]  slot_per [dott_pkg::NUM_SLOTS];
  logic [1:0]                     slot_rm [dott_pkg::NUM_SLOTS];
  bit                             slot_inited [dott_pkg::NUM_SLOTS];
  logic [dott_pkg::LIM_BITS-1:0]  jump_lim;

  dott_pkg::out_item_t pending_firings[$];  // expiries still to come out
  dott_pkg::out_item_t update_firings[$];   // expiries of the latest transfer
  int                  errors = 0;
  bit                  quiet = 1'b0;        // no idling on either side when set
  int                  rx_hold = 0;

  // Works out the expiries for one accepted input transfer and updates the
  // table copy. The results land in update_firings.
  function automatic void fire_order(input dott_pkg::in_item_t it);
    logic [dott_pkg::PER_BITS-1:0]  per;
    logic [1:0]                     rm;
    logic [dott_pkg::TIME_BITS-1:0] t;
    logic [dott_pkg::TIME_BITS-1:0] biased_now;
    logic [dott_pkg::TIME_BITS-1:0] fix;
    logic [dott_pkg::TIME_BITS:0]   dl;
    logic [dott_pkg::TIME_BITS:0]   best_dl;
    int                             best;
    dott_pkg::out_item_t            r;
    update_firings.delete();
    per = (it.delay_value == '0) ? dott_pkg::PER_BITS'(1) : it.delay_value;
    // Run mode code three behaves as a one-shot timer.
    rm = (it.run_mode == dott_pkg::RUN_ALIAS) ? dott_pkg::RUN_ONCE : it.run_mode;
    case (it.mode)
      dott_pkg::CMD_INIT: begin
        slot_per[it.timer_slot] = per;
        slot_lr[it.timer_slot] = now_time - dott_pkg::TIME_BITS'(per);
        slot_rm[it.timer_slot] = rm;
        slot_inited[it.timer_slot] = 1'b1;
      end
      dott_pkg::CMD_REARM: begin
        slot_per[it.timer_slot] = per;
        slot_rm[it.timer_slot] = rm;
      end
      dott_pkg::CMD_STOP: slot_rm[it.timer_slot] = dott_pkg::RUN_OFF;
      dott_pkg::CMD_CHG:  slot_per[it.timer_slot] = per;
      dott_pkg::CMD_UPDATE: begin
        t = it.new_time;
        if (t != now_time) begin
          // A step backwards, or forwards by more than the jump limit, is a
          // clock jump: armed timers move with the clock.
          if ($signed(t) < $signed(now_time) ||
              (t - now_time) > dott_pkg::TIME_BITS'(jump_lim)) begin
            fix = t - now_time - dott_pkg::TIME_BITS'(1);
            for (int i = 0; i < dott_pkg::NUM_SLOTS; i++)
              if (slot_rm[i] != dott_pkg::RUN_OFF) slot_lr[i] = slot_lr[i] + fix;
          end
          now_time = t;
          biased_now = t ^ dott_pkg::TIME_SIGN;
          // Deadlines are compared in biased form with a carry bit, so a
          // deadline past the top of the time range never fires.
          for (int n = 0; n < dott_pkg::NUM_SLOTS; n++) begin
            best = -1;
            best_dl = '0;
            for (int i = 0; i < dott_pkg::NUM_SLOTS; i++) begin
              if (slot_rm[i] != dott_pkg::RUN_OFF) begin
                dl = {1'b0, slot_lr[i] ^ dott_pkg::TIME_SIGN} +
                     (dott_pkg::TIME_BITS+1)'(slot_per[i]);
                if (!dl[dott_pkg::TIME_BITS] && {1'b0, biased_now} > dl &&
                    (best < 0 || dl < best_dl)) begin
                  best = i;
                  best_dl = dl;
                end
              end
            end
            if (best < 0) break;
            slot_lr[best] = now_time;
            if (slot_rm[best] != dott_pkg::RUN_REPEAT) slot_rm[best] = dott_pkg::RUN_OFF;
            r.fired_slot = best[dott_pkg::SLOT_BITS-1:0];
            r.last_fired = 1'b0;
            update_firings.push_back(r);
          end
          if (update_firings.size() > 0)
            update_firings[update_firings.size()-1].last_fired = 1'b1;
        end
      end
      default: ;  // unused command codes are ignored
    endcase
    foreach (update_firings[k]) pending_firings.push_back(update_firings[k]);
  endfunction

  // Output side: check every transfer and stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_firings.size() == 0) begin
          $display("%0t: unexpected expiry: expected none, actual slot %0d last %0b",
                   $time, out_item.fired_slot, out_item.last_fired);
          errors++;
        end else begin
          if (out_item.fired_slot !== pending_firings[0].fired_slot) begin
            $display("%0t: fired_slot mismatch: expected %0d, actual %0d",
                     $time, pending_firings[0].fired_slot, out_item.fired_slot);
            errors++;
          end
          if (out_item.last_fired !== pending_firings[0].last_fired) begin
            $display("%0t: last_fired mismatch: expected %0b, actual %0b",
                     $time, pending_firings[0].last_fired, out_item.last_fired);
            errors++;
          end
          void'(pending_firings.pop_front());
        end
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        rx_hold <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Presents one item, waits for its transfer, predicts, then maybe idles.
  task automatic send_item(input dott_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    fire_order(it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Lets every expected expiry out, then gives an update that fires nothing
  // enough cycles to finish its closing scan.
  task automatic drain_table();
    in_valid <= 1'b0;
    while (pending_firings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_jump_limit(input logic [dott_pkg::LIM_BITS-1:0] v);
    drain_table();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    jump_lim = v;
  endtask

  function automatic dott_pkg::in_item_t mk(input logic [2:0] md, input int sl,
                                            input logic [31:0] dly,
                                            input logic [1:0] rm,
                                            input logic [dott_pkg::TIME_BITS-1:0] tm);
    dott_pkg::in_item_t it;
    it.mode = md;
    it.timer_slot = sl[dott_pkg::SLOT_BITS-1:0];
    it.delay_value = dly;
    it.run_mode = rm;
    it.new_time = tm;
    return it;
  endfunction

  // Random 48-bit time anywhere in the range.
  function automatic logic [dott_pkg::TIME_BITS-1:0] rand_time();
    return dott_pkg::TIME_BITS'({$urandom, $urandom});
  endfunction

  // Directed table row: an expectation is typed in only where it is plain;
  // exp_n of -1 leaves the row to the predictor alone.
  typedef struct {
    dott_pkg::in_item_t  it;
    int                  exp_n;
    dott_pkg::out_item_t exp_first;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input dott_pkg::in_item_t it, input int n,
                                  input int sl, input bit lst);
    dir_row_t row;
    row.it = it;
    row.exp_n = n;
    row.exp_first.fired_slot = sl[dott_pkg::SLOT_BITS-1:0];
    row.exp_first.last_fired = lst;
    dir_rows.push_back(row);
  endfunction

  // Picks a random item, mostly well-formed timer traffic that walks time
  // forward in small steps so that timers keep expiring.
  function automatic dott_pkg::in_item_t rand_item();
    dott_pkg::in_item_t             it;
    int                             pick;
    int                             sl;
    logic [31:0]                    dly;
    logic [dott_pkg::TIME_BITS-1:0] tm;
    pick = $urandom_range(0, 99);
    sl = $urandom_range(0, dott_pkg::NUM_SLOTS-1);
    dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
    tm = now_time + dott_pkg::TIME_BITS'($urandom_range(1, 8));
    if (pick < 8) tm = now_time;                                         // repeated
    else if (pick < 14) tm = now_time - dott_pkg::TIME_BITS'($urandom_range(1, 500));
    else if (pick < 20) tm = now_time + dott_pkg::TIME_BITS'($urandom_range(2, 70000));
    else if (pick < 24) tm = rand_time();                                // anywhere
    if (pick < 45)
      it = mk(dott_pkg::CMD_UPDATE, sl, $urandom, 2'($urandom), tm);
    else if (pick < 70 || (pick < 80 && !slot_inited[sl]))
      it = mk(dott_pkg::CMD_INIT, sl, dly, 2'($urandom_range(0, 3)), rand_time());
    else if (pick < 80)
      it = mk(dott_pkg::CMD_REARM, sl, dly, 2'($urandom_range(0, 3)), rand_time());
    else if (pick < 88)
      it = mk(dott_pkg::CMD_STOP, sl, $urandom, 2'($urandom), rand_time());
    else
      it = mk(dott_pkg::CMD_CHG, sl, dly, 2'($urandom), rand_time());
    return it;
  endfunction

  initial begin
    dott_pkg::in_item_t it;
    int                 sent;
    now_time = '0;
    jump_lim = dott_pkg::JUMP_LIMIT_RESET;
    for (int i = 0; i < dott_pkg::NUM_SLOTS; i++) begin
      slot_lr[i] = '0;
      slot_per[i] = '0;
      slot_rm[i] = dott_pkg::RUN_OFF;
      slot_inited[i] = 1'b0;
    end

    // Directed part: repeated time, clamped delay, ties, extremes of the
    // fields, a jump to each end of the time range and unused codes.
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd10), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_INIT, 0, 32'd0, dott_pkg::RUN_ONCE, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd11), 1, 0, 1'b1);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd30), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_INIT, 15, 32'hFFFF_FFFF, dott_pkg::RUN_REPEAT, 48'd0),
            0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_INIT, 3, 32'd5, dott_pkg::RUN_ALIAS, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_INIT, 7, 32'd5, dott_pkg::RUN_REPEAT, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd31), 3, 3, 1'b0);
    add_row(mk(dott_pkg::CMD_REARM, 3, 32'd2, dott_pkg::RUN_ONCE, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_CHG, 15, 32'd1, 2'd0, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'd35), -1, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_STOP, 7, 32'd0, 2'd0, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'h7FFF_FFFF_FFFF), -1, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_INIT, 9, 32'd3, dott_pkg::RUN_ONCE, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'h8000_0000_0000), -1, 0, 1'b0);
    add_row(mk(3'd5, 1, 32'hFFFF_FFFF, 2'd3, '1), 0, 0, 1'b0);
    add_row(mk(3'd7, 2, 32'd0, 2'd0, '0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_REARM, 9, 32'd1, dott_pkg::RUN_OFF, 48'd0), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'h8000_0000_0000), 0, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, 48'h8000_0000_0100), -1, 0, 1'b0);
    add_row(mk(dott_pkg::CMD_UPDATE, 0, 32'd0, 2'd0, '1), -1, 0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].it);
      if (dir_rows[r].exp_n >= 0) begin
        if (update_firings.size() != dir_rows[r].exp_n) begin
          $display("%0t: row %0d expiry count: expected %0d, actual %0d",
                   $time, r, dir_rows[r].exp_n, update_firings.size());
          errors++;
        end else if (dir_rows[r].exp_n > 0 &&
                     update_firings[0] != dir_rows[r].exp_first) begin
          $display("%0t: row %0d first expiry: expected %p, actual %p",
                   $time, r, dir_rows[r].exp_first, update_firings[0]);
          errors++;
        end
      end
    end

    // Random part under several jump limits, the extremes among them.
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_jump_limit(16'd1);
        1: set_jump_limit(16'hFFFF);
        2: set_jump_limit(16'($urandom_range(2, 400)));
        3: set_jump_limit(dott_pkg::JUMP_LIMIT_RESET);
        default: set_jump_limit(16'($urandom_range(1, 65535)));
      endcase
      if (ph == 4) quiet = 1'b1;
      for (int k = 0; k < 30; k++) begin
        it = rand_item();
        // Sprinkle unused command codes as noise; they are not counted.
        if ($urandom_range(0, 19) == 0)
          send_item(mk(3'($urandom_range(5, 7)), $urandom, $urandom, 2'($urandom),
                       rand_time()));
        send_item(it);
        sent++;
        // Hold the sender off until the table has emptied its expiries.
        if (ph == 2 && k == 15) drain_table();
      end
    end

    drain_table();
    if (errors == 0 && pending_firings.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dott_pkg.sv
rtl/core/dott_slot_mem.sv
rtl/core/dott_seq.sv
rtl/core/deadline_ordered_timer_table_core.sv
dv/deadline_ordered_timer_table_core_tb.sv
